// ===== rtl/core/bps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types, codes and constants of the bouncing projectile step unit.
// ----------------------------------------------------------------------------
package bps_pkg;

   localparam int WordW = 32;

   // result status codes
   localparam logic [1:0] STATUS_NONE    = 2'd0;
   localparam logic [1:0] STATUS_BOUNCE  = 2'd1;
   localparam logic [1:0] STATUS_STOPPED = 2'd2;

   // request kinds
   localparam logic REQ_LAUNCH = 1'b0;
   localparam logic REQ_STEP   = 1'b1;

   // register indexes
   localparam int CsrIdxW = 4;
   localparam logic [CsrIdxW-1:0] CSR_GRAVITY      = 4'd0;
   localparam logic [CsrIdxW-1:0] CSR_GROUND_LEVEL = 4'd1;
   localparam logic [CsrIdxW-1:0] CSR_BALL_RADIUS  = 4'd2;
   localparam logic [CsrIdxW-1:0] CSR_RESTITUTION  = 4'd3;
   localparam logic [CsrIdxW-1:0] CSR_X_LOW        = 4'd4;
   localparam logic [CsrIdxW-1:0] CSR_X_HIGH       = 4'd5;
   localparam logic [CsrIdxW-1:0] CSR_Z_LOW        = 4'd6;
   localparam logic [CsrIdxW-1:0] CSR_Z_HIGH       = 4'd7;

   // register reset values
   localparam logic [30:0]        GRAVITY_RST     = 31'd642252;
   localparam logic signed [31:0] GROUND_RST      = 32'sd0;
   localparam logic [30:0]        RADIUS_RST      = 31'd6554;
   localparam logic [16:0]        RESTITUTION_RST = 17'd52429;
   localparam logic signed [31:0] X_LOW_RST       = -32'sd327680;
   localparam logic signed [31:0] X_HIGH_RST      = 32'sd327680;
   localparam logic signed [31:0] Z_LOW_RST       = -32'sd327680;
   localparam logic signed [31:0] Z_HIGH_RST      = 32'sd327680;

   // shared multiplier operations
   localparam int MulOpW = 4;
   localparam logic [MulOpW-1:0] MUL_NONE = 4'd0;
   localparam logic [MulOpW-1:0] MUL_TT   = 4'd1;
   localparam logic [MulOpW-1:0] MUL_VX   = 4'd2;
   localparam logic [MulOpW-1:0] MUL_VY   = 4'd3;
   localparam logic [MulOpW-1:0] MUL_VZ   = 4'd4;
   localparam logic [MulOpW-1:0] MUL_GT   = 4'd5;
   localparam logic [MulOpW-1:0] MUL_GULO = 4'd6;
   localparam logic [MulOpW-1:0] MUL_GUHI = 4'd7;
   localparam logic [MulOpW-1:0] MUL_BNC  = 4'd8;
   localparam logic [MulOpW-1:0] MUL_SQ0  = 4'd9;
   localparam logic [MulOpW-1:0] MUL_SQ1  = 4'd10;
   localparam logic [MulOpW-1:0] MUL_SQ2  = 4'd11;
   localparam logic [MulOpW-1:0] MUL_LSQ0 = 4'd12;
   localparam logic [MulOpW-1:0] MUL_LSQ1 = 4'd13;
   localparam logic [MulOpW-1:0] MUL_LSQ2 = 4'd14;

   typedef struct packed {
      logic                load_launch;
      logic                load_step;
      logic                update_pos;
      logic                detect;
      logic                decide;
      logic [MulOpW-1:0]   mul_op;
   } ctl_cmd_type;

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [31:0] r;
      if (v > 68'sh0_0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -68'sh0_0000_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bps_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bps_req_if / bps_rsp_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
interface bps_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic signed [31:0] time_value;
   logic signed [31:0] launch_x;
   logic signed [31:0] launch_y;
   logic signed [31:0] launch_z;
   logic signed [31:0] launch_vx;
   logic signed [31:0] launch_vy;
   logic signed [31:0] launch_vz;

   modport source (output valid, req_type, time_value, launch_x, launch_y, launch_z,
                   launch_vx, launch_vy, launch_vz, input ready);
   modport sink   (input valid, req_type, time_value, launch_x, launch_y, launch_z,
                   launch_vx, launch_vy, launch_vz, output ready);
endinterface

interface bps_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   logic signed [31:0] segment_time;

   modport source (output valid, status, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                   segment_time, input ready);
   modport sink   (input valid, status, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                   segment_time, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bouncing_projectile_step_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bouncing_projectile_step_unit
// Ballistic projectile stepper with restitution bounces off floor and walls.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes one request at a time: a launch (start position, velocity,
//   time) or a step (time since the current segment began). Each request
//   gives exactly one result on rsp_chan: status, position, velocity and the
//   segment start time; all but status are Q16.16 by default.
//   One shared 33x33 multiplier carries all products, one per cycle while a
//   request is worked; a step with a contact needs more products than one
//   without, and a launch needs the fewest.
//   The next request is taken in the cycle after the result is accepted.
//   The result stays valid and stable while the receiver holds ready low.
//   Reset (synchronous) clears flight state to zero and loads register
//   defaults; csr writes take effect at once and belong between requests.
// ----------------------------------------------------------------------------
module bouncing_projectile_step_unit #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   bps_req_if.sink          req_chan,
   bps_rsp_if.source        rsp_chan,
   input  wire logic        csr_write_enable,
   input  wire logic [bps_pkg::CsrIdxW-1:0] csr_index,
   input  wire logic [31:0] csr_data
);

   bps_pkg::ctl_cmd_type cmd;
   logic                 hit;
   logic signed [31:0]   in_pos [3];
   logic signed [31:0]   in_vel [3];
   logic signed [31:0]   cur_pos [3];
   logic signed [31:0]   cur_vel [3];

   assign in_pos[0] = req_chan.launch_x;
   assign in_pos[1] = req_chan.launch_y;
   assign in_pos[2] = req_chan.launch_z;
   assign in_vel[0] = req_chan.launch_vx;
   assign in_vel[1] = req_chan.launch_vy;
   assign in_vel[2] = req_chan.launch_vz;

   bps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.req_type),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .hit       (hit),
      .cmd       (cmd)
   );

   bps_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .hit              (hit),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .in_time          (req_chan.time_value),
      .in_pos           (in_pos),
      .in_vel           (in_vel),
      .status           (rsp_chan.status),
      .cur_pos          (cur_pos),
      .cur_vel          (cur_vel),
      .seg_time         (rsp_chan.segment_time)
   );

   assign rsp_chan.pos_x = cur_pos[0];
   assign rsp_chan.pos_y = cur_pos[1];
   assign rsp_chan.pos_z = cur_pos[2];
   assign rsp_chan.vel_x = cur_vel[0];
   assign rsp_chan.vel_y = cur_vel[1];
   assign rsp_chan.vel_z = cur_vel[2];

endmodule
`default_nettype wire

// ===== rtl/core/bps_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bps_ctrl
// Sequencer: issues multiplier operations and datapath actions per request.
// ----------------------------------------------------------------------------
module bps_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_kind,
   output      logic                 req_ready,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire logic                 hit,
   output      bps_pkg::ctl_cmd_type cmd
);

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_LSQ0    = 5'd1;
   localparam logic [4:0] ST_LSQ1    = 5'd2;
   localparam logic [4:0] ST_LSQ2    = 5'd3;
   localparam logic [4:0] ST_LDRAIN  = 5'd4;
   localparam logic [4:0] ST_TT      = 5'd5;
   localparam logic [4:0] ST_VX      = 5'd6;
   localparam logic [4:0] ST_GULO    = 5'd7;
   localparam logic [4:0] ST_GUHI    = 5'd8;
   localparam logic [4:0] ST_VY      = 5'd9;
   localparam logic [4:0] ST_VZ      = 5'd10;
   localparam logic [4:0] ST_GT      = 5'd11;
   localparam logic [4:0] ST_GDRAIN  = 5'd12;
   localparam logic [4:0] ST_POS     = 5'd13;
   localparam logic [4:0] ST_HIT     = 5'd14;
   localparam logic [4:0] ST_BNC     = 5'd15;
   localparam logic [4:0] ST_BDRAIN  = 5'd16;
   localparam logic [4:0] ST_SQ0     = 5'd17;
   localparam logic [4:0] ST_SQ1     = 5'd18;
   localparam logic [4:0] ST_SQ2     = 5'd19;
   localparam logic [4:0] ST_SDRAIN  = 5'd20;
   localparam logic [4:0] ST_DECIDE  = 5'd21;
   localparam logic [4:0] ST_OUT     = 5'd22;

   logic [4:0] state_ff, state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.mul_op      = bps_pkg::MUL_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == bps_pkg::REQ_LAUNCH) begin
                  cmd.load_launch = 1'b1;
                  state_in        = ST_LSQ0;
               end else begin
                  cmd.load_step = 1'b1;
                  state_in      = ST_TT;
               end
            end
         end
         ST_LSQ0: begin cmd.mul_op = bps_pkg::MUL_LSQ0; state_in = ST_LSQ1;   end
         ST_LSQ1: begin cmd.mul_op = bps_pkg::MUL_LSQ1; state_in = ST_LSQ2;   end
         ST_LSQ2: begin cmd.mul_op = bps_pkg::MUL_LSQ2; state_in = ST_LDRAIN; end
         ST_LDRAIN: state_in = ST_OUT;
         ST_TT:   begin cmd.mul_op = bps_pkg::MUL_TT;   state_in = ST_VX;     end
         ST_VX:   begin cmd.mul_op = bps_pkg::MUL_VX;   state_in = ST_GULO;   end
         ST_GULO: begin cmd.mul_op = bps_pkg::MUL_GULO; state_in = ST_GUHI;   end
         ST_GUHI: begin cmd.mul_op = bps_pkg::MUL_GUHI; state_in = ST_VY;     end
         ST_VY:   begin cmd.mul_op = bps_pkg::MUL_VY;   state_in = ST_VZ;     end
         ST_VZ:   begin cmd.mul_op = bps_pkg::MUL_VZ;   state_in = ST_GT;     end
         ST_GT:   begin cmd.mul_op = bps_pkg::MUL_GT;   state_in = ST_GDRAIN; end
         ST_GDRAIN: state_in = ST_POS;
         ST_POS:  begin cmd.update_pos = 1'b1; state_in = ST_HIT; end
         ST_HIT:  begin cmd.detect = 1'b1;     state_in = ST_BNC; end
         ST_BNC: begin
            if (hit) begin
               cmd.mul_op = bps_pkg::MUL_BNC;
               state_in   = ST_BDRAIN;
            end else begin
               state_in   = ST_OUT;
            end
         end
         ST_BDRAIN: state_in = ST_SQ0;
         ST_SQ0:  begin cmd.mul_op = bps_pkg::MUL_SQ0; state_in = ST_SQ1;    end
         ST_SQ1:  begin cmd.mul_op = bps_pkg::MUL_SQ1; state_in = ST_SQ2;    end
         ST_SQ2:  begin cmd.mul_op = bps_pkg::MUL_SQ2; state_in = ST_SDRAIN; end
         ST_SDRAIN: state_in = ST_DECIDE;
         ST_DECIDE: begin cmd.decide = 1'b1; state_in = ST_OUT; end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/bps_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bps_datapath
// Registers, shared 33x33 multiplier and the position/contact arithmetic.
// ----------------------------------------------------------------------------
module bps_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bps_pkg::ctl_cmd_type cmd,
   output      logic                 hit,
   input  wire logic                 csr_write_enable,
   input  wire logic [bps_pkg::CsrIdxW-1:0] csr_index,
   input  wire logic [31:0]          csr_data,
   input  wire logic signed [31:0]   in_time,
   input  wire logic signed [31:0]   in_pos [3],
   input  wire logic signed [31:0]   in_vel [3],
   output      logic [1:0]           status,
   output      logic signed [31:0]   cur_pos [3],
   output      logic signed [31:0]   cur_vel [3],
   output      logic signed [31:0]   seg_time
);

   localparam logic [95:0] DropLimit = 96'd1 << 60;

   // configuration
   logic [30:0]        gravity_ff;
   logic signed [31:0] ground_ff;
   logic [30:0]        radius_ff;
   logic [16:0]        rest_ff;
   logic signed [31:0] xlo_ff, xhi_ff, zlo_ff, zhi_ff;

   // flight state
   logic signed [31:0] seg_pos_ff [3];
   logic signed [31:0] seg_vel_ff [3];
   logic signed [31:0] cur_pos_ff [3];
   logic signed [31:0] prev_pos_ff [3];
   logic signed [31:0] cur_vel_ff [3];
   logic signed [31:0] seg_start_ff;
   logic [63:0]        ref_sq_ff;

   // per-request scratch
   logic signed [31:0] t_ff;
   logic [31:0]        tm_ff;
   logic [63:0]        u_ff;
   logic signed [63:0] fx_ff, fy_ff, fz_ff, fg_ff;
   logic [63:0]        glo_ff, ghi_ff;
   logic [63:0]        now_sq_ff;
   logic [1:0]         axis_ff;
   logic               hit_ff;
   logic [1:0]         status_ff;

   // multiplier
   logic signed [32:0] op_a, op_b;
   logic signed [65:0] prod_ff;
   logic [bps_pkg::MulOpW-1:0] mul_d_ff;

   logic signed [67:0] prod_ext, prod_sh;
   logic signed [32:0] t_neg;
   logic [95:0]        g_sum, g_shift;
   logic [60:0]        drop;
   logic signed [33:0] y_lo, x_lo, x_hi, z_lo, z_hi;
   logic               c_ground, c_xlo, c_xhi, c_zlo, c_zhi;
   logic [68:0]        now_x20;
   logic               stop;

   assign t_neg    = -{in_time[31], in_time};
   assign prod_ext = {{2{prod_ff[65]}}, prod_ff};
   assign prod_sh  = prod_ext >>> FRAC_BITS;

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (cmd.mul_op)
         bps_pkg::MUL_TT:   begin op_a = {1'b0, tm_ff}; op_b = {1'b0, tm_ff}; end
         bps_pkg::MUL_VX:   begin
            op_a = {seg_vel_ff[0][31], seg_vel_ff[0]}; op_b = {t_ff[31], t_ff};
         end
         bps_pkg::MUL_VY:   begin
            op_a = {seg_vel_ff[1][31], seg_vel_ff[1]}; op_b = {t_ff[31], t_ff};
         end
         bps_pkg::MUL_VZ:   begin
            op_a = {seg_vel_ff[2][31], seg_vel_ff[2]}; op_b = {t_ff[31], t_ff};
         end
         bps_pkg::MUL_GT:   begin op_a = {2'b0, gravity_ff}; op_b = {t_ff[31], t_ff}; end
         bps_pkg::MUL_GULO: begin op_a = {2'b0, gravity_ff}; op_b = {1'b0, u_ff[31:0]}; end
         bps_pkg::MUL_GUHI: begin op_a = {2'b0, gravity_ff}; op_b = {1'b0, u_ff[63:32]}; end
         bps_pkg::MUL_BNC:  begin
            op_a = {cur_vel_ff[axis_ff][31], cur_vel_ff[axis_ff]}; op_b = {16'b0, rest_ff};
         end
         bps_pkg::MUL_SQ0:  begin
            op_a = {cur_vel_ff[0][31], cur_vel_ff[0]}; op_b = op_a;
         end
         bps_pkg::MUL_SQ1:  begin
            op_a = {cur_vel_ff[1][31], cur_vel_ff[1]}; op_b = op_a;
         end
         bps_pkg::MUL_SQ2:  begin
            op_a = {cur_vel_ff[2][31], cur_vel_ff[2]}; op_b = op_a;
         end
         bps_pkg::MUL_LSQ0: begin
            op_a = {cur_vel_ff[0][31], cur_vel_ff[0]}; op_b = op_a;
         end
         bps_pkg::MUL_LSQ1: begin
            op_a = {cur_vel_ff[1][31], cur_vel_ff[1]}; op_b = op_a;
         end
         bps_pkg::MUL_LSQ2: begin
            op_a = {cur_vel_ff[2][31], cur_vel_ff[2]}; op_b = op_a;
         end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   // gravity drop: floor(g*u / 2^(F+1)), clamped
   always_comb begin
      g_sum   = {ghi_ff, 32'b0} + {32'b0, glo_ff};
      g_shift = g_sum >> (FRAC_BITS + 1);
      drop    = (g_shift > DropLimit) ? DropLimit[60:0] : g_shift[60:0];
   end

   // contact tests, wide enough to hold position +/- radius
   always_comb begin
      y_lo = {{2{cur_pos_ff[1][31]}}, cur_pos_ff[1]} - {3'b0, radius_ff};
      x_lo = {{2{cur_pos_ff[0][31]}}, cur_pos_ff[0]} - {3'b0, radius_ff};
      x_hi = {{2{cur_pos_ff[0][31]}}, cur_pos_ff[0]} + {3'b0, radius_ff};
      z_lo = {{2{cur_pos_ff[2][31]}}, cur_pos_ff[2]} - {3'b0, radius_ff};
      z_hi = {{2{cur_pos_ff[2][31]}}, cur_pos_ff[2]} + {3'b0, radius_ff};
      c_ground = (y_lo < $signed({{2{ground_ff[31]}}, ground_ff})) &&
                 (cur_pos_ff[1] < prev_pos_ff[1]);
      c_xlo    = (x_lo < $signed({{2{xlo_ff[31]}}, xlo_ff})) &&
                 (cur_pos_ff[0] < prev_pos_ff[0]);
      c_xhi    = (x_hi > $signed({{2{xhi_ff[31]}}, xhi_ff})) &&
                 (cur_pos_ff[0] > prev_pos_ff[0]);
      c_zlo    = (z_lo < $signed({{2{zlo_ff[31]}}, zlo_ff})) &&
                 (cur_pos_ff[2] < prev_pos_ff[2]);
      c_zhi    = (z_hi > $signed({{2{zhi_ff[31]}}, zhi_ff})) &&
                 (cur_pos_ff[2] > prev_pos_ff[2]);
   end

   // stopped when 20*|v|^2 < |v_launch|^2
   assign now_x20 = ({5'b0, now_sq_ff} << 4) + ({5'b0, now_sq_ff} << 2);
   assign stop    = now_x20 < {5'b0, ref_sq_ff};

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;

      if (reset) begin
         gravity_ff   <= bps_pkg::GRAVITY_RST;
         ground_ff    <= bps_pkg::GROUND_RST;
         radius_ff    <= bps_pkg::RADIUS_RST;
         rest_ff      <= bps_pkg::RESTITUTION_RST;
         xlo_ff       <= bps_pkg::X_LOW_RST;
         xhi_ff       <= bps_pkg::X_HIGH_RST;
         zlo_ff       <= bps_pkg::Z_LOW_RST;
         zhi_ff       <= bps_pkg::Z_HIGH_RST;
         mul_d_ff     <= bps_pkg::MUL_NONE;
         seg_start_ff <= '0;
         ref_sq_ff    <= '0;
         status_ff    <= bps_pkg::STATUS_NONE;
         hit_ff       <= 1'b0;
         axis_ff      <= '0;
         for (int i = 0; i < 3; i++) begin
            seg_pos_ff[i]  <= '0;
            seg_vel_ff[i]  <= '0;
            cur_pos_ff[i]  <= '0;
            prev_pos_ff[i] <= '0;
            cur_vel_ff[i]  <= '0;
         end
      end else begin
         mul_d_ff <= cmd.mul_op;

         if (csr_write_enable) begin
            case (csr_index)
               bps_pkg::CSR_GRAVITY:      gravity_ff <= csr_data[30:0];
               bps_pkg::CSR_GROUND_LEVEL: ground_ff  <= csr_data;
               bps_pkg::CSR_BALL_RADIUS:  radius_ff  <= csr_data[30:0];
               bps_pkg::CSR_RESTITUTION:  rest_ff    <= csr_data[16:0];
               bps_pkg::CSR_X_LOW:        xlo_ff     <= csr_data;
               bps_pkg::CSR_X_HIGH:       xhi_ff     <= csr_data;
               bps_pkg::CSR_Z_LOW:        zlo_ff     <= csr_data;
               bps_pkg::CSR_Z_HIGH:       zhi_ff     <= csr_data;
               default: ;
            endcase
         end

         if (cmd.load_launch) begin
            for (int i = 0; i < 3; i++) begin
               seg_pos_ff[i]  <= in_pos[i];
               cur_pos_ff[i]  <= in_pos[i];
               prev_pos_ff[i] <= in_pos[i];
               seg_vel_ff[i]  <= in_vel[i];
               cur_vel_ff[i]  <= in_vel[i];
            end
            seg_start_ff <= in_time;
            ref_sq_ff    <= '0;
            status_ff    <= bps_pkg::STATUS_NONE;
         end

         if (cmd.load_step) begin
            t_ff      <= in_time;
            tm_ff     <= in_time[31] ? t_neg[31:0] : in_time;
            status_ff <= bps_pkg::STATUS_NONE;
            hit_ff    <= 1'b0;
         end

         // consume the product of the operation issued in the previous cycle
         case (mul_d_ff)
            bps_pkg::MUL_TT:   u_ff   <= prod_ff[63:0] >> FRAC_BITS;
            bps_pkg::MUL_VX:   fx_ff  <= prod_sh[63:0];
            bps_pkg::MUL_VY:   fy_ff  <= prod_sh[63:0];
            bps_pkg::MUL_VZ:   fz_ff  <= prod_sh[63:0];
            bps_pkg::MUL_GT:   fg_ff  <= prod_sh[63:0];
            bps_pkg::MUL_GULO: glo_ff <= prod_ff[63:0];
            bps_pkg::MUL_GUHI: ghi_ff <= prod_ff[63:0];
            bps_pkg::MUL_BNC:  begin
               cur_vel_ff[axis_ff] <= bps_pkg::sat32(-prod_sh);
               now_sq_ff           <= '0;
            end
            bps_pkg::MUL_SQ0, bps_pkg::MUL_SQ1, bps_pkg::MUL_SQ2:
               now_sq_ff <= now_sq_ff + prod_ff[63:0];
            bps_pkg::MUL_LSQ0, bps_pkg::MUL_LSQ1, bps_pkg::MUL_LSQ2:
               ref_sq_ff <= ref_sq_ff + prod_ff[63:0];
            default: ;
         endcase

         if (cmd.update_pos) begin
            for (int i = 0; i < 3; i++) begin
               prev_pos_ff[i] <= cur_pos_ff[i];
            end
            cur_pos_ff[0] <= bps_pkg::sat32({{36{seg_pos_ff[0][31]}}, seg_pos_ff[0]} +
                                            {{4{fx_ff[63]}}, fx_ff});
            cur_pos_ff[2] <= bps_pkg::sat32({{36{seg_pos_ff[2][31]}}, seg_pos_ff[2]} +
                                            {{4{fz_ff[63]}}, fz_ff});
            cur_pos_ff[1] <= bps_pkg::sat32({{36{seg_pos_ff[1][31]}}, seg_pos_ff[1]} +
                                            {{4{fy_ff[63]}}, fy_ff} - {7'b0, drop});
            cur_vel_ff[0] <= seg_vel_ff[0];
            cur_vel_ff[2] <= seg_vel_ff[2];
            cur_vel_ff[1] <= bps_pkg::sat32({{36{seg_vel_ff[1][31]}}, seg_vel_ff[1]} -
                                            {{4{fg_ff[63]}}, fg_ff});
         end

         if (cmd.detect) begin
            hit_ff <= c_ground || c_xlo || c_xhi || c_zlo || c_zhi;
            if (c_ground) begin
               axis_ff <= 2'd1;
            end else if (c_xlo || c_xhi) begin
               axis_ff <= 2'd0;
            end else begin
               axis_ff <= 2'd2;
            end
         end

         if (cmd.decide) begin
            if (stop) begin
               status_ff <= bps_pkg::STATUS_STOPPED;
            end else begin
               status_ff <= bps_pkg::STATUS_BOUNCE;
               for (int i = 0; i < 3; i++) begin
                  seg_pos_ff[i] <= cur_pos_ff[i];
                  seg_vel_ff[i] <= cur_vel_ff[i];
               end
               seg_start_ff <= bps_pkg::sat32({{36{seg_start_ff[31]}}, seg_start_ff} +
                                              {{36{t_ff[31]}}, t_ff});
            end
         end
      end
   end

   assign hit      = hit_ff;
   assign status   = status_ff;
   assign cur_pos  = cur_pos_ff;
   assign cur_vel  = cur_vel_ff;
   assign seg_time = seg_start_ff;

endmodule
`default_nettype wire
